// File: rtl/core/lbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbm_pkg;

    // Pipeline depth shared by the control path and the channel datapaths.
    localparam int STAGES = 20;

    // Configuration port geometry and register indexes.
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 15;
    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE     = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDE_EPSILON = 4'd1;

    // Blend mode codes.
    localparam logic [4:0] M_NORMAL     = 5'd0;
    localparam logic [4:0] M_ADD        = 5'd1;
    localparam logic [4:0] M_SUBTRACT   = 5'd2;
    localparam logic [4:0] M_MULTIPLY   = 5'd3;
    localparam logic [4:0] M_SCREEN     = 5'd4;
    localparam logic [4:0] M_OVERLAY    = 5'd5;
    localparam logic [4:0] M_SOFT_LIGHT = 5'd6;
    localparam logic [4:0] M_HARD_LIGHT = 5'd7;
    localparam logic [4:0] M_DIFFERENCE = 5'd8;
    localparam logic [4:0] M_EXCLUSION  = 5'd9;
    localparam logic [4:0] M_LIGHTEN    = 5'd10;
    localparam logic [4:0] M_DARKEN     = 5'd11;
    localparam logic [4:0] M_DODGE      = 5'd12;
    localparam logic [4:0] M_BURN       = 5'd13;
    localparam logic [4:0] M_LIN_DODGE  = 5'd14;
    localparam logic [4:0] M_LIN_BURN   = 5'd15;
    localparam logic [4:0] M_VIVID      = 5'd16;
    localparam logic [4:0] M_LIN_LIGHT  = 5'd17;
    localparam logic [4:0] M_PIN_LIGHT  = 5'd18;
    localparam logic [4:0] M_HARD_MIX   = 5'd19;
    localparam logic [4:0] M_DIVIDE     = 5'd20;
    localparam logic [4:0] M_AVERAGE    = 5'd21;

    // Input word: backdrop RGB and source RGBA, signed Q4.12.
    typedef struct packed {
        logic signed [15:0] backdrop_red;
        logic signed [15:0] backdrop_green;
        logic signed [15:0] backdrop_blue;
        logic signed [15:0] source_red;
        logic signed [15:0] source_green;
        logic signed [15:0] source_blue;
        logic signed [15:0] source_alpha;
    } t_lbm_in;

    // Output word: blended RGB and the source alpha.
    typedef struct packed {
        logic signed [15:0] out_red;
        logic signed [15:0] out_green;
        logic signed [15:0] out_blue;
        logic signed [15:0] out_alpha;
    } t_lbm_out;

endpackage

`default_nettype wire

// File: rtl/core/lbm_chan.sv
`timescale 1ns / 1ps
`default_nettype none

module lbm_chan (
    input  logic                             i_clk,
    input  logic [lbm_pkg::STAGES-1:0]       i_en,
    input  logic [4:0]                       i_mode,
    input  logic [lbm_pkg::CFG_DATA_W-1:0]   i_eps,
    input  logic signed [15:0]               i_b,
    input  logic signed [15:0]               i_s,
    output logic signed [15:0]               o_res
);

    localparam int DIV_BITS = 15;
    localparam int SQ_BITS  = 13;
    localparam int S_STEP0  = 3;
    localparam int S_POST   = S_STEP0 + DIV_BITS;
    localparam int S_OUT    = S_POST + 1;

    // How the final value of a word is formed after the iterative units.
    typedef enum logic [2:0] {
        K_EARLY  = 3'd0,
        K_DODGE  = 3'd1,
        K_BURN   = 3'd2,
        K_DIVIDE = 3'd3,
        K_SOFT   = 3'd4
    } t_kind;

    typedef struct packed {
        logic signed [15:0] b;
        logic signed [15:0] s;
        logic [12:0]        bc;
        logic [12:0]        sc;
        logic signed [16:0] sum_bs;
        logic               hl_lo;
        logic               sl_lo;
        logic signed [15:0] early;
        t_kind              kind;
        logic               neg;
        logic               ovf;
        logic [27:0]        n_rem;
        logic [15:0]        dvs;
        logic [DIV_BITS-1:0] q;
        logic signed [31:0] p_bs;
        logic signed [33:0] p_cc;
        logic [22:0]        m1;
        logic signed [27:0] t1;
        logic [35:0]        m2;
        logic signed [42:0] t2;
        logic signed [13:0] d_poly;
        logic [SQ_BITS-1:0] sq_r;
        logic [24:0]        sq_rem;
        logic signed [27:0] sl_mul;
    } t_st;

    t_st r_st [lbm_pkg::STAGES];
    t_st n_st [lbm_pkg::STAGES];

    function automatic logic signed [15:0] f_sat(input logic signed [35:0] x);
        if (x > 36'sd32767) begin
            return 16'sh7fff;
        end else if (x < -36'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    // Stage 0: register the channel pair and clamp it for soft light.
    always_comb begin
        n_st[0] = '0;
        n_st[0].b = i_b;
        n_st[0].s = i_s;
        n_st[0].sum_bs = 17'(i_b) + 17'(i_s);
        if (i_b < 16'sd0) begin
            n_st[0].bc = 13'd0;
        end else if (i_b > 16'sd4096) begin
            n_st[0].bc = 13'd4096;
        end else begin
            n_st[0].bc = i_b[12:0];
        end
        if (i_s < 16'sd0) begin
            n_st[0].sc = 13'd0;
        end else if (i_s > 16'sd4096) begin
            n_st[0].sc = 13'd4096;
        end else begin
            n_st[0].sc = i_s[12:0];
        end
    end

    // Stage 1: simple modes, first products, divider and root setup.
    always_comb begin : c_s1
        t_st                p;
        logic signed [19:0] b20;
        logic signed [19:0] s20;
        logic signed [19:0] simp;
        logic signed [16:0] cb;
        logic signed [16:0] cs;
        logic [12:0]        nb;
        logic signed [17:0] lin;
        logic signed [17:0] sp;
        logic               do_dodge;
        logic               do_burn;
        logic signed [16:0] s17;
        logic signed [16:0] b17;
        logic [16:0]        abs_s;
        logic [16:0]        abs_b;
        logic [15:0]        cnum;

        p = r_st[0];
        n_st[1] = p;
        b20 = 20'(p.b);
        s20 = 20'(p.s);

        case (i_mode)
            lbm_pkg::M_NORMAL:     simp = s20;
            lbm_pkg::M_ADD,
            lbm_pkg::M_LIN_DODGE:  simp = b20 + s20;
            lbm_pkg::M_SUBTRACT:   simp = b20 - s20;
            lbm_pkg::M_DIFFERENCE: simp = (b20 > s20) ? (b20 - s20) : (s20 - b20);
            lbm_pkg::M_LIGHTEN:    simp = (b20 > s20) ? b20 : s20;
            lbm_pkg::M_DARKEN:     simp = (b20 < s20) ? b20 : s20;
            lbm_pkg::M_LIN_BURN:   simp = b20 + s20 - 20'sd4096;
            lbm_pkg::M_LIN_LIGHT: begin
                simp = b20 + (s20 <<< 1) - 20'sd4096;
                if (simp < 20'sd0) begin
                    simp = 20'sd0;
                end else if (simp > 20'sd4096) begin
                    simp = 20'sd4096;
                end
            end
            lbm_pkg::M_PIN_LIGHT: begin
                if (s20 <= 20'sd2048) begin
                    simp = (b20 < (s20 <<< 1)) ? b20 : (s20 <<< 1);
                end else begin
                    simp = (b20 > ((s20 <<< 1) - 20'sd4096)) ? b20
                                                             : ((s20 <<< 1) - 20'sd4096);
                end
            end
            lbm_pkg::M_HARD_MIX:   simp = ((b20 + s20) >= 20'sd4096) ? 20'sd4096 : 20'sd0;
            lbm_pkg::M_AVERAGE:    simp = (b20 + s20 + 20'sd1) >>> 1;
            default:               simp = s20;
        endcase
        n_st[1].early = f_sat(36'(simp));
        n_st[1].kind  = K_EARLY;
        n_st[1].neg   = 1'b0;
        n_st[1].n_rem = '0;
        n_st[1].dvs   = 16'd1;
        n_st[1].q     = '0;

        // Products for multiply, screen, exclusion, overlay and hard light.
        cb = 17'sd4096 - 17'(p.b);
        cs = 17'sd4096 - 17'(p.s);
        n_st[1].p_bs = p.b * p.s;
        n_st[1].p_cc = cb * cs;
        n_st[1].hl_lo = (i_mode == lbm_pkg::M_OVERLAY) ? (p.b <= 16'sd2048)
                                                       : (p.s <= 16'sd2048);

        // Soft light polynomial terms on the clamped pair.
        nb = 13'd4096 - p.bc;
        n_st[1].m1 = 23'(p.bc) * 23'(nb);
        lin = $signed({1'b0, p.bc, 4'd0}) - 18'sd49152;
        n_st[1].t1 = 28'(lin) * 28'($signed({1'b0, p.bc}));
        n_st[1].sl_lo = (p.sc <= 13'd2048);
        n_st[1].sq_r = '0;
        n_st[1].sq_rem = {p.bc, 12'd0};
        if (i_mode == lbm_pkg::M_SOFT_LIGHT && p.sc > 13'd2048) begin
            n_st[1].kind = K_SOFT;
        end

        // Dodge, burn and vivid light: edge cases now, the quotient later.
        do_dodge = 1'b0;
        do_burn  = 1'b0;
        sp = 18'(p.s);
        case (i_mode)
            lbm_pkg::M_DODGE: do_dodge = 1'b1;
            lbm_pkg::M_BURN:  do_burn = 1'b1;
            lbm_pkg::M_VIVID: begin
                if (p.s <= 16'sd2048) begin
                    do_burn = 1'b1;
                    sp = 18'(p.s) <<< 1;
                end else begin
                    do_dodge = 1'b1;
                    sp = (18'(p.s) <<< 1) - 18'sd4096;
                end
            end
            default: ;
        endcase
        cnum = 16'(17'sd4096 - 17'(p.b));
        if (do_dodge) begin
            if (p.b <= 16'sd0) begin
                n_st[1].early = 16'sd0;
            end else if (sp >= 18'sd4096) begin
                n_st[1].early = 16'sd4096;
            end else begin
                n_st[1].kind  = K_DODGE;
                n_st[1].n_rem = {1'b0, p.b[14:0], 12'd0};
                n_st[1].dvs   = 16'(18'sd4096 - sp);
            end
        end
        if (do_burn) begin
            if (p.b >= 16'sd4096) begin
                n_st[1].early = 16'sd4096;
            end else if (sp <= 18'sd0) begin
                n_st[1].early = 16'sd0;
            end else begin
                n_st[1].kind  = K_BURN;
                n_st[1].n_rem = {cnum, 12'd0};
                n_st[1].dvs   = sp[15:0];
            end
        end

        // Divide works on magnitudes; the sign is restored at the end.
        s17 = 17'(p.s);
        b17 = 17'(p.b);
        abs_s = (s17 < 17'sd0) ? 17'(-s17) : 17'(s17);
        abs_b = (b17 < 17'sd0) ? 17'(-b17) : 17'(b17);
        if (i_mode == lbm_pkg::M_DIVIDE) begin
            if (abs_s > {2'b00, i_eps}) begin
                n_st[1].kind  = K_DIVIDE;
                n_st[1].n_rem = {abs_b[15:0], 12'd0};
                n_st[1].dvs   = abs_s[15:0];
                n_st[1].neg   = p.b[15] ^ p.s[15];
            end else begin
                n_st[1].early = 16'sd0;
            end
        end
    end

    // Stage 2: round the product modes, second soft light products, overflow.
    always_comb begin : c_s2
        t_st                p;
        logic signed [35:0] x;
        logic signed [28:0] tt;
        logic [13:0]        f;
        logic               is_prod;

        p = r_st[1];
        n_st[2] = p;
        is_prod = 1'b1;
        case (i_mode)
            lbm_pkg::M_MULTIPLY:  x = 36'(p.p_bs);
            lbm_pkg::M_SCREEN:    x = (36'(p.sum_bs) <<< 12) - 36'(p.p_bs);
            lbm_pkg::M_EXCLUSION: x = (36'(p.sum_bs) <<< 12) - (36'(p.p_bs) <<< 1);
            lbm_pkg::M_OVERLAY,
            lbm_pkg::M_HARD_LIGHT: begin
                x = p.hl_lo ? (36'(p.p_bs) <<< 1)
                            : (36'sd16777216 - (36'(p.p_cc) <<< 1));
            end
            default: begin
                x = '0;
                is_prod = 1'b0;
            end
        endcase
        if (is_prod) begin
            n_st[2].early = f_sat((x + 36'sd2048) >>> 12);
        end

        f = 14'd4096 - {p.sc, 1'b0};
        n_st[2].m2 = 36'(p.m1) * 36'(f);
        tt = 29'(p.t1) + 29'sd67108864;
        n_st[2].t2 = 43'(tt) * 43'($signed({1'b0, p.bc}));
        n_st[2].ovf = ({3'b000, p.n_rem} >= {p.dvs, 15'd0});
    end

    // Stages 3 to 17: one quotient bit a stage; the root joins for its 13 bits.
    for (genvar k = S_STEP0; k < S_POST; k++) begin : g_step
        localparam int I = S_POST - 1 - k;

        always_comb begin : c_step
            t_st         p;
            logic [30:0] dsh;
            logic [26:0] trial;
            logic [37:0] lo;

            p = r_st[k-1];
            n_st[k] = p;

            // First step stage also finishes the soft light polynomials.
            lo = 38'({p.bc, 24'd0}) - 38'(p.m2) + 38'd8388608;
            if (k == S_STEP0) begin
                n_st[k].d_poly = 14'((p.t2 + 43'sd8388608) >>> 24);
                if (i_mode == lbm_pkg::M_SOFT_LIGHT && p.sl_lo) begin
                    n_st[k].early = 16'(lo >> 24);
                end
            end

            // Restoring division step.
            dsh = 31'(p.dvs) << I;
            if ({3'b000, p.n_rem} >= dsh) begin
                n_st[k].n_rem = p.n_rem - dsh[27:0];
                n_st[k].q[I]  = 1'b1;
            end

            // Square root step: try the next root bit against the remainder.
            trial = '0;
            if (I < SQ_BITS) begin
                trial = (27'(p.sq_r) << (I + 1)) + (27'd1 << (2 * I));
                if (27'(p.sq_rem) >= trial) begin
                    n_st[k].sq_rem = p.sq_rem - trial[24:0];
                    n_st[k].sq_r[I] = 1'b1;
                end
            end
        end
    end

    // Stage 18: resolve quotients and form the soft light correction product.
    always_comb begin : c_post
        t_st                p;
        logic [DIV_BITS-1:0] v;
        logic signed [14:0] dsel;
        logic signed [14:0] dd;
        logic signed [14:0] g;

        p = r_st[S_POST-1];
        n_st[S_POST] = p;
        v = (p.ovf || p.q > 15'd4096) ? 15'd4096 : p.q;
        case (p.kind)
            K_DODGE: n_st[S_POST].early = 16'(v);
            K_BURN:  n_st[S_POST].early = 16'sd4096 - $signed(16'(v));
            K_DIVIDE: begin
                if (p.neg) begin
                    n_st[S_POST].early = p.ovf ? 16'sh8000 : -$signed({1'b0, p.q});
                end else begin
                    n_st[S_POST].early = p.ovf ? 16'sh7fff : $signed({1'b0, p.q});
                end
            end
            default: ;
        endcase
        dsel = (p.bc <= 13'd1024) ? 15'(p.d_poly) : $signed({2'b00, p.sq_r});
        dd = dsel - $signed({2'b00, p.bc});
        g = $signed({1'b0, p.sc, 1'b0}) - 15'sd4096;
        n_st[S_POST].sl_mul = 28'(g) * 28'(dd);
    end

    // Stage 19: soft light upper half and its saturation.
    always_comb begin : c_out
        t_st p;

        p = r_st[S_OUT-1];
        n_st[S_OUT] = p;
        if (p.kind == K_SOFT) begin
            n_st[S_OUT].early = f_sat(36'($signed({1'b0, p.bc}))
                                      + ((36'(p.sl_mul) + 36'sd2048) >>> 12));
        end
    end

    // Stage registers advance on their own enables.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < lbm_pkg::STAGES; k++) begin
            if (i_en[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_res = r_st[S_OUT].early;

endmodule

`default_nettype wire

// File: rtl/core/layer_blend_mode_pixel.sv
// Throughput: one word per cycle unless i_stall holds the pipeline; a 15-stage
// restoring divider and a 13-step square root per channel are laid out as pipeline stages.
// Stalled stages hold; empty stages keep filling, so bubbles close up.
// Reset empties the pipeline and sets blend mode to normal and epsilon to 1.
`timescale 1ns / 1ps
`default_nettype none

module layer_blend_mode_pixel (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  lbm_pkg::t_lbm_in                    i_pix,
    output logic                                o_valid,
    input  logic                                i_stall,
    output lbm_pkg::t_lbm_out                   o_pix,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lbm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lbm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic [4:0]                      r_mode;
    logic [lbm_pkg::CFG_DATA_W-1:0]  r_eps;
    logic [lbm_pkg::STAGES-1:0]      r_vld;
    logic [lbm_pkg::STAGES:0]        w_rdy;
    logic signed [15:0]              r_alpha [lbm_pkg::STAGES];
    logic signed [15:0]              w_red;
    logic signed [15:0]              w_green;
    logic signed [15:0]              w_blue;

    // Configuration registers accept a write in every cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= lbm_pkg::M_NORMAL;
            r_eps  <= 15'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                lbm_pkg::REG_BLEND_MODE:     r_mode <= i_cfg_data[4:0];
                lbm_pkg::REG_DIVIDE_EPSILON: r_eps <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage may load when it is empty or the stage after it moves.
    assign w_rdy[lbm_pkg::STAGES] = !i_stall;
    for (genvar k = 0; k < lbm_pkg::STAGES; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    assign o_stall = !w_rdy[0];

    // Valid bits travel with the data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < lbm_pkg::STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Alpha rides along unchanged.
    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_alpha[0] <= i_pix.source_alpha;
        end
        for (int k = 1; k < lbm_pkg::STAGES; k++) begin
            if (w_rdy[k]) begin
                r_alpha[k] <= r_alpha[k-1];
            end
        end
    end

    // One datapath per colour channel.
    lbm_chan u_red (
        .i_clk  (i_clk),
        .i_en   (w_rdy[lbm_pkg::STAGES-1:0]),
        .i_mode (r_mode),
        .i_eps  (r_eps),
        .i_b    (i_pix.backdrop_red),
        .i_s    (i_pix.source_red),
        .o_res  (w_red)
    );

    lbm_chan u_green (
        .i_clk  (i_clk),
        .i_en   (w_rdy[lbm_pkg::STAGES-1:0]),
        .i_mode (r_mode),
        .i_eps  (r_eps),
        .i_b    (i_pix.backdrop_green),
        .i_s    (i_pix.source_green),
        .o_res  (w_green)
    );

    lbm_chan u_blue (
        .i_clk  (i_clk),
        .i_en   (w_rdy[lbm_pkg::STAGES-1:0]),
        .i_mode (r_mode),
        .i_eps  (r_eps),
        .i_b    (i_pix.backdrop_blue),
        .i_s    (i_pix.source_blue),
        .o_res  (w_blue)
    );

    assign o_valid         = r_vld[lbm_pkg::STAGES-1];
    assign o_pix.out_red   = w_red;
    assign o_pix.out_green = w_green;
    assign o_pix.out_blue  = w_blue;
    assign o_pix.out_alpha = r_alpha[lbm_pkg::STAGES-1];

endmodule

`default_nettype wire
